// ===== rtl/wf3_pkg.sv =====
// ----------------------------------------------------------------------------
// wf3_pkg: shared types and constants of the 3x3 window filter
// Pixel width, window column type, line store word and kernel codes.
// ----------------------------------------------------------------------------
package wf3_pkg;

    localparam int IMG_WIDTH_DEF  = 256;
    localparam int IMG_HEIGHT_DEF = 256;

    localparam int PIX_W   = 8;
    localparam int SUM_W   = 12;    // nine 8-bit pixels
    localparam int SIDE_W  = 10;    // three 8-bit pixels
    localparam int RECIP_W = 13;

    // floor(x / 9) == (x * BOX_RECIP) >> BOX_SHIFT for x up to 9 * 255
    localparam logic [RECIP_W-1:0] BOX_RECIP = 13'd7282;
    localparam int                 BOX_SHIFT = 16;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // kernel select codes
    localparam logic KSEL_BOX     = 1'b0;
    localparam logic KSEL_PREWITT = 1'b1;

    // one window column, top to bottom
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } col_t;

    // one line store word: row r-1 in mid, row r-2 in up
    typedef struct packed {
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] up;
    } line_t;

    localparam int LINE_W = 2 * PIX_W;

endpackage

// ===== rtl/wf3_ram.sv =====
// ----------------------------------------------------------------------------
// wf3_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, hold data when not reading
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/wf3_cell.sv =====
// ----------------------------------------------------------------------------
// wf3_cell: one window column
// Holds three vertically stacked pixels and takes its neighbor's column
// on every shift.
// ----------------------------------------------------------------------------
module wf3_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          shift_en,
    input  wf3_pkg::col_t col_in,
    output wf3_pkg::col_t col_out
);

    wf3_pkg::col_t col_reg;

    // load the neighbor's column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (shift_en) begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

// ===== rtl/wf3_kernel.sv =====
// ----------------------------------------------------------------------------
// wf3_kernel: box mean and horizontal Prewitt datapath
// First stage sums the window and the gradient magnitude, second stage
// divides the box sum by nine and selects the result.
// ----------------------------------------------------------------------------
module wf3_kernel (
    input  logic                        aclk,
    input  logic                        en,
    input  logic                        kernel_select,
    input  wf3_pkg::col_t               left_col,
    input  wf3_pkg::col_t               centre_col,
    input  wf3_pkg::col_t               right_col,
    output logic [wf3_pkg::PIX_W-1:0]   value
);

    logic [wf3_pkg::SIDE_W-1:0]  left_sum;
    logic [wf3_pkg::SIDE_W-1:0]  right_sum;
    logic [wf3_pkg::SIDE_W-1:0]  centre_sum;
    logic [wf3_pkg::SIDE_W-1:0]  diff;
    logic [wf3_pkg::SUM_W-1:0]   box_sum;
    logic [wf3_pkg::PIX_W-1:0]   mag_sat;

    logic [wf3_pkg::SUM_W-1:0]   sum_reg;
    logic [wf3_pkg::PIX_W-1:0]   mag_reg;
    logic                        sel_reg;

    logic [wf3_pkg::SUM_W+wf3_pkg::RECIP_W-1:0] prod;
    logic [wf3_pkg::PIX_W-1:0]   mean;
    logic [wf3_pkg::PIX_W-1:0]   value_reg;
    logic [wf3_pkg::PIX_W-1:0]   value_next;

    // column sums
    assign left_sum   = wf3_pkg::SIDE_W'(left_col.top) + wf3_pkg::SIDE_W'(left_col.mid)
                      + wf3_pkg::SIDE_W'(left_col.bot);
    assign right_sum  = wf3_pkg::SIDE_W'(right_col.top) + wf3_pkg::SIDE_W'(right_col.mid)
                      + wf3_pkg::SIDE_W'(right_col.bot);
    assign centre_sum = wf3_pkg::SIDE_W'(centre_col.top) + wf3_pkg::SIDE_W'(centre_col.mid)
                      + wf3_pkg::SIDE_W'(centre_col.bot);
    assign box_sum    = wf3_pkg::SUM_W'(left_sum) + wf3_pkg::SUM_W'(right_sum)
                      + wf3_pkg::SUM_W'(centre_sum);

    // absolute gradient, saturated to a pixel
    assign diff    = (right_sum >= left_sum) ? (right_sum - left_sum) : (left_sum - right_sum);
    assign mag_sat = (diff > wf3_pkg::SIDE_W'(wf3_pkg::PIX_MAX)) ? wf3_pkg::PIX_MAX
                                                                 : diff[wf3_pkg::PIX_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= box_sum;
            mag_reg <= mag_sat;
            sel_reg <= kernel_select;
        end
    end

    // divide by nine through the reciprocal
    assign prod = (wf3_pkg::SUM_W+wf3_pkg::RECIP_W)'(sum_reg)
                * (wf3_pkg::SUM_W+wf3_pkg::RECIP_W)'(wf3_pkg::BOX_RECIP);
    assign mean = prod[wf3_pkg::BOX_SHIFT +: wf3_pkg::PIX_W];

    always_comb begin
        case (sel_reg)
            wf3_pkg::KSEL_PREWITT: value_next = mag_reg;
            default:               value_next = mean;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ===== rtl/window_filter_3x3.sv =====
// ----------------------------------------------------------------------------
// window_filter_3x3: 3x3 box mean / horizontal Prewitt over a pixel stream
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_tvalid/s_tready  | tdata: pixel; tuser: frame_start
//   cfg_    | in  | cfg_valid/cfg_ready| cfg_data: kernel_select
//   m_      | out | m_tvalid/m_tready  | tdata: value,row,col; tlast: last
//
// One pixel per cycle while no result is held; m_tvalid rises once its pixel
// has passed the line store read at accept, window shift, sums, divide by nine.
// The line stores are one RAM with registered read; a write to the column
// just read is forwarded to the next item.
// Reset clears counters, window, kernel select and all valid flags; the
// line stores are not cleared.
// A result held with m_tready low stalls the whole pipeline and drops s_tready.
// ----------------------------------------------------------------------------
module window_filter_3x3 #(
    parameter int IMG_WIDTH  = wf3_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = wf3_pkg::IMG_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] pixel
    input  logic        s_tuser,    // [0] frame_start

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,   // kernel_select

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] value, [15:8] row, [23:16] col
    output logic        m_tlast
);

    localparam int CW = $clog2(IMG_WIDTH);
    localparam int RW = $clog2(IMG_HEIGHT);
    localparam logic [CW-1:0] COL_LAST = CW'(IMG_WIDTH - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(IMG_HEIGHT - 1);
    localparam logic [CW-1:0] COL_TWO  = CW'(2);
    localparam logic [RW-1:0] ROW_TWO  = RW'(2);

    logic en;
    logic accept;

    // kernel select register
    logic ksel_reg;

    // position counters
    logic [CW-1:0] col_reg, col_next, col_cur;
    logic [RW-1:0] row_reg, row_next, row_cur;

    // stage 1: line store read in flight
    logic                      s1_valid_reg;
    logic                      s1_emit_reg;
    logic                      s1_last_reg;
    logic [CW-1:0]             s1_col_reg;
    logic [7:0]                s1_row_o_reg;
    logic [7:0]                s1_col_o_reg;
    logic [wf3_pkg::PIX_W-1:0] s1_px_reg;
    logic                      byp_valid_reg;
    wf3_pkg::line_t            byp_data_reg;

    // stage 2 and 3 controls, output stage
    logic       s2_valid_reg, s3_valid_reg, m_valid_reg;
    logic       s2_last_reg,  s3_last_reg,  m_last_reg;
    logic [7:0] s2_row_reg,   s3_row_reg,   m_row_reg;
    logic [7:0] s2_col_reg,   s3_col_reg,   m_col_reg;

    logic                      emit;
    logic                      last;
    logic                      hazard;
    logic [RW+7:0]             row_wide;
    logic [CW+7:0]             col_wide;
    logic [wf3_pkg::LINE_W-1:0] ram_rd;
    wf3_pkg::line_t            line_rd;
    wf3_pkg::line_t            line_cur;
    wf3_pkg::line_t            wr_data;
    logic                      step;

    wf3_pkg::col_t             new_col;
    wf3_pkg::col_t             cell_col [3];
    logic [wf3_pkg::PIX_W-1:0] value;

    assign en        = !m_valid_reg || m_tready;
    assign s_tready  = en;
    assign accept    = s_tvalid && en;
    assign cfg_ready = 1'b1;
    assign step      = en && s1_valid_reg;

    // hold kernel select
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ksel_reg <= wf3_pkg::KSEL_BOX;
        end else if (cfg_valid) begin
            ksel_reg <= cfg_data;
        end
    end

    // position of the incoming word and the next position
    always_comb begin
        col_cur  = s_tuser ? '0 : col_reg;
        row_cur  = s_tuser ? '0 : row_reg;
        col_next = col_cur + CW'(1);
        row_next = row_cur;
        if (col_cur == COL_LAST) begin
            col_next = '0;
            row_next = (row_cur == ROW_LAST) ? '0 : row_cur + RW'(1);
        end
    end

    assign emit     = (row_cur >= ROW_TWO) && (col_cur >= COL_TWO);
    assign last     = (row_cur == ROW_LAST) && (col_cur == COL_LAST);
    assign row_wide = {8'b0, RW'(row_cur - RW'(1))};
    assign col_wide = {8'b0, CW'(col_cur - CW'(1))};
    assign hazard   = s1_valid_reg && (col_cur == s1_col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_emit_reg   <= emit;
            s1_last_reg   <= last;
            s1_col_reg    <= col_cur;
            s1_row_o_reg  <= row_wide[7:0];
            s1_col_o_reg  <= col_wide[7:0];
            s1_px_reg     <= s_tdata;
            byp_valid_reg <= hazard;
            byp_data_reg  <= wr_data;
        end
    end

    // line stores: read at accept, written back when the window steps
    wf3_ram #(
        .WIDTH (wf3_pkg::LINE_W),
        .DEPTH (IMG_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (step),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (ram_rd)
    );

    assign line_rd  = wf3_pkg::line_t'(ram_rd);
    assign line_cur = byp_valid_reg ? byp_data_reg : line_rd;

    // move the middle row up, drop the new pixel into the middle row
    always_comb begin
        wr_data.up  = line_cur.mid;
        wr_data.mid = s1_px_reg;
    end

    assign new_col.top = line_cur.up;
    assign new_col.mid = line_cur.mid;
    assign new_col.bot = s1_px_reg;

    // window: rightmost cell takes the new column, the others their neighbor's
    for (genvar i = 0; i < 3; i++) begin : g_cell
        wf3_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (step),
            .col_in   ((i == 2) ? new_col : cell_col[(i + 1) % 3]),
            .col_out  (cell_col[i])
        );
    end

    wf3_kernel u_kernel (
        .aclk          (aclk),
        .en            (en),
        .kernel_select (ksel_reg),
        .left_col      (cell_col[0]),
        .centre_col    (cell_col[1]),
        .right_col     (cell_col[2]),
        .value         (value)
    );

    // advance result controls alongside the datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;
            m_valid_reg  <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_last_reg <= s1_last_reg;
            s2_row_reg  <= s1_row_o_reg;
            s2_col_reg  <= s1_col_o_reg;
            s3_last_reg <= s2_last_reg;
            s3_row_reg  <= s2_row_reg;
            s3_col_reg  <= s2_col_reg;
            m_last_reg  <= s3_last_reg;
            m_row_reg   <= s3_row_reg;
            m_col_reg   <= s3_col_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_col_reg, m_row_reg, value};
    assign m_tlast  = m_last_reg;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 3x3 window filter
// Streams runs of pixels through the filter with random gaps on the pixel
// side and random stalls on the result side, predicts each result from
// its own copy of the line stores and window, and compares every result
// word field by field. The kernel select is rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int IMG_W          = wf3_pkg::IMG_WIDTH_DEF;
    localparam int IMG_H          = wf3_pkg::IMG_HEIGHT_DEF;
    localparam int PRIME_PX       = 2 * IMG_W + 40;
    localparam int AFTER_RESTART  = 2 * IMG_W + 100;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_GAP        = 11;
    localparam int PRINT_LIMIT    = 50;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } px_item_t;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] row;
        logic [7:0] col;
        logic       last;
    } filt_res_t;

    typedef enum int unsigned { RUN_CARRY, RUN_RESTART, RUN_STARTS } run_kind_e;
    typedef enum int unsigned { PS_UNIFORM, PS_EXTREME, PS_STRIPE, PS_DARK } pixel_style_e;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // [7:0] pixel
    logic        s_tuser   = 1'b0;  // [0] frame_start
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;  // kernel_select
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;           // [7:0] value, [15:8] row, [23:16] col
    logic        m_tlast;

    // pending pixels and expected filter results
    px_item_t    pixel_queue[$];
    filt_res_t   expected_res[$];
    int unsigned px_sent  = 0;
    int unsigned px_taken = 0;
    int unsigned err_count = 0;

    // column of the next queued pixel and a fixed vertical stripe pattern
    int unsigned q_col = 0;
    logic [7:0]  stripe_col[IMG_W];

    // shadow of the filter state
    logic [7:0]  up_line [IMG_W];
    logic [7:0]  mid_line[IMG_W];
    logic [7:0]  win[3][3];         // [row: top..bottom][col: left..right]
    int unsigned pos_col;
    int unsigned pos_row;
    logic        filt_kernel;

    bit          src_burst  = 1'b0;
    bit          sink_burst = 1'b0;
    int unsigned src_wait   = 0;
    int unsigned sink_wait  = 0;
    int unsigned stall_cycles = 0;
    px_item_t    drv_item;

    window_filter_3x3 #(
        .IMG_WIDTH (IMG_W),
        .IMG_HEIGHT(IMG_H)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // print one line per mismatch (capped) and count it
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("tb: mismatch on %s: got %0d, want %0d at %0t", what, got, want, $time);
    endtask

    // shift the window by one pixel and queue the result it yields, if any
    task automatic predict_pixel(input logic [7:0] px, input logic fs);
        int unsigned r, c, k, sum_all, sum_l, sum_r, mag;
        logic [7:0]  up, mid;
        filt_res_t   res;
        if (fs) begin
            pos_col = 0;
            pos_row = 0;
        end
        r   = pos_row;
        c   = pos_col;
        up  = up_line[c];
        mid = mid_line[c];
        for (k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = px;
        up_line[c]  = mid;
        mid_line[c] = px;

        if (r >= 2 && c >= 2) begin
            sum_all = 0;
            sum_l   = 0;
            sum_r   = 0;
            for (k = 0; k < 3; k++) begin
                sum_all += win[k][0] + win[k][1] + win[k][2];
                sum_l   += win[k][0];
                sum_r   += win[k][2];
            end
            if (filt_kernel == wf3_pkg::KSEL_PREWITT) begin
                mag = (sum_r >= sum_l) ? sum_r - sum_l : sum_l - sum_r;
                res.value = (mag > wf3_pkg::PIX_MAX) ? wf3_pkg::PIX_MAX : mag[7:0];
            end else begin
                mag = sum_all / 9;
                res.value = mag[7:0];
            end
            res.row  = 8'(r - 1);
            res.col  = 8'(c - 1);
            res.last = (r == IMG_H - 1) && (c == IMG_W - 1);
            expected_res.push_back(res);
        end

        // advance the raster position, wrapping at the end of the frame
        c++;
        if (c >= IMG_W) begin
            c = 0;
            r++;
            if (r >= IMG_H)
                r = 0;
        end
        pos_col = c;
        pos_row = r;
    endtask

    // compare one result word with the oldest expectation
    task automatic check_result(input logic [23:0] data, input logic tl);
        filt_res_t want;
        if (expected_res.size() == 0) begin
            report_mismatch("result with nothing pending, value", data[7:0], 0);
            return;
        end
        want = expected_res.pop_front();
        if (data[7:0] !== want.value)
            report_mismatch("value", data[7:0], want.value);
        if (data[15:8] !== want.row)
            report_mismatch("row", data[15:8], want.row);
        if (data[23:16] !== want.col)
            report_mismatch("col", data[23:16], want.col);
        if (tl !== want.last)
            report_mismatch("last", tl, want.last);
    endtask

    // pixel driver: hold a word until taken, then idle for the drawn gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_wait <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (src_wait != 0) begin
                s_tvalid <= 1'b0;
                src_wait <= src_wait - 1;
            end else if (pixel_queue.size() != 0) begin
                drv_item = pixel_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= drv_item.pixel;
                s_tuser  <= drv_item.frame_start;
                src_wait <= src_burst ? 0 : $urandom_range(0, MAX_GAP);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result sink: drop ready for a drawn number of cycles after each word
    always @(posedge aclk) begin : sink_ctl
        int unsigned hold;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            hold = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
            sink_wait <= hold;
            m_tready  <= (hold == 0);
        end else if (sink_wait > 1) begin
            sink_wait <= sink_wait - 1;
        end else begin
            sink_wait <= 0;
            m_tready  <= 1'b1;
        end
    end

    // monitor: predict on every pixel taken, check every result taken
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_pixel(s_tdata, s_tuser);
                px_taken++;
            end
            if (m_tvalid && m_tready)
                check_result(m_tdata, m_tlast);
        end
    end

    // watchdog: end the run when no word moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // queue one pixel and track the column of the next one
    task automatic push_pixel(input logic [7:0] px, input logic fs);
        px_item_t item;
        item.pixel       = px;
        item.frame_start = fs;
        pixel_queue.push_back(item);
        px_sent++;
        q_col = fs ? 1 : q_col + 1;
        if (q_col >= IMG_W)
            q_col = 0;
    endtask

    // wait for every pixel and result, then let the pipeline run empty
    task automatic wait_idle();
        int unsigned open_cycles;
        open_cycles = 0;
        while (px_taken != px_sent || expected_res.size() != 0)
            @(posedge aclk);
        while (open_cycles < DRAIN_CYCLES) begin
            @(posedge aclk);
            if (m_tready)
                open_cycles++;
        end
    endtask

    task automatic write_kernel(input logic ksel);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= ksel;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        filt_kernel = ksel;
    endtask

    // queue one run of pixels of the given kind
    task automatic queue_run(input run_kind_e kind);
        int unsigned  len, i, col;
        pixel_style_e style;
        logic [7:0]   px;
        logic         fs;
        style = pixel_style_e'($urandom_range(0, 3));
        case (kind)
            RUN_RESTART: len = $urandom_range(1, 20);
            RUN_STARTS:  len = $urandom_range(2, 6);
            default:     len = $urandom_range(20, 120);
        endcase
        for (i = 0; i < len; i++) begin
            case (kind)
                RUN_STARTS:  fs = 1'b1;
                RUN_RESTART: fs = (i == 0);
                default:     fs = 1'b0;
            endcase
            col = fs ? 0 : q_col;
            case (style)
                PS_UNIFORM: px = 8'($urandom_range(0, 255));
                PS_EXTREME: px = $urandom_range(0, 1) ? wf3_pkg::PIX_MAX : 8'd0;
                PS_STRIPE:  px = stripe_col[col];
                default:    px = 8'($urandom_range(0, 15));
            endcase
            push_pixel(px, fs);
        end
    endtask

    initial begin : stimulus
        int unsigned i, phase_no, nruns, restart_px;

        foreach (up_line[k]) begin
            up_line[k]  = '0;
            mid_line[k] = '0;
        end
        foreach (stripe_col[k])
            stripe_col[k] = $urandom_range(0, 1) ? wf3_pkg::PIX_MAX : 8'd0;
        for (i = 0; i < 9; i++)
            win[i / 3][i % 3] = '0;
        pos_col     = 0;
        pos_row     = 0;
        filt_kernel = wf3_pkg::KSEL_BOX;
        restart_px  = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_kernel(wf3_pkg::KSEL_BOX);

        // two rows and a bit of vertical stripes: box means up to the maximum level
        for (i = 0; i < PRIME_PX; i++)
            push_pixel(stripe_col[i % IMG_W], i == 0);
        wait_idle();

        // finish the third row under the gradient: stripe edges saturate
        write_kernel(wf3_pkg::KSEL_PREWITT);
        for (i = PRIME_PX; i < 3 * IMG_W; i++)
            push_pixel(stripe_col[i % IMG_W], 1'b0);
        wait_idle();

        // random phases, kernel rewritten while the filter is idle
        phase_no = 0;
        while (px_sent < RANDOM_ITEMS || px_sent < restart_px + AFTER_RESTART) begin
            case (phase_no % 4)
                0:       write_kernel(wf3_pkg::KSEL_PREWITT);
                1:       write_kernel(wf3_pkg::KSEL_BOX);
                default: write_kernel($urandom_range(0, 1) ? wf3_pkg::KSEL_PREWITT
                                                           : wf3_pkg::KSEL_BOX);
            endcase
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            // restart the frame mid-frame once, with frame starts back to back
            if (phase_no == 1) begin
                src_burst  = 1'b1;
                restart_px = px_sent;
                queue_run(RUN_STARTS);
                queue_run(RUN_RESTART);
            end
            nruns = $urandom_range(1, 3);
            repeat (nruns)
                queue_run(RUN_CARRY);
            wait_idle();
            phase_no++;
        end

        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
